/* design/rbb_pkg.sv */
`timescale 1ns / 1ps
// rbb_pkg: shared constants, types and helpers for the raw12 bayer binning block
// no dependencies

package rbb_pkg;

   // line store depth, one entry per column
   localparam int MAX_GROUPS = 2048;
   localparam int COL_W      = $clog2(MAX_GROUPS);

   // field widths
   localparam int GROUP_W = 24;
   localparam int PIX_W   = 8;
   localparam int PAIR_W  = 2 * PIX_W;
   localparam int GPR_W   = 12;

   // row length register after reset
   localparam logic [GPR_W-1:0] GPR_RESET = GPR_W'(2048);

   // width wide enough for both the register and the store depth
   localparam int LEN_W = (GPR_W > COL_W + 1) ? GPR_W : COL_W + 1;

   // column position handed from the row control to the datapath
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic             last;
      logic             odd;
   } rbb_pos_type;

   // index of the last column, with a zero length acting as one
   // and an oversized length clamped to the store depth
   function automatic logic [COL_W-1:0] last_col(input logic [GPR_W-1:0] gpr);
      logic [LEN_W-1:0] len;
      logic [LEN_W-1:0] len_m1;
      len = LEN_W'(gpr);
      if (len == '0) begin
         len = LEN_W'(1);
      end
      if (len > LEN_W'(MAX_GROUPS)) begin
         len = LEN_W'(MAX_GROUPS);
      end
      len_m1 = len - LEN_W'(1);
      return len_m1[COL_W-1:0];
   endfunction

endpackage

/* design/rbb_if.sv */
`timescale 1ns / 1ps
// rbb_req_if / rbb_rsp_if: valid-ready channels of the binning block
// depends on rbb_pkg

interface rbb_req_if
   import rbb_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [GROUP_W-1:0] packed_group;

   modport source (output valid, output packed_group, input ready);
   modport sink   (input valid, input packed_group, output ready);
endinterface

interface rbb_rsp_if
   import rbb_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green_first;
   logic [PIX_W-1:0] green_second;
   logic [PIX_W-1:0] blue;
   logic [PIX_W-1:0] green_mean;
   logic             row_end;

   modport source (output valid, output red, output green_first, output green_second,
                   output blue, output green_mean, output row_end, input ready);
   modport sink   (input valid, input red, input green_first, input green_second,
                   input blue, input green_mean, input row_end, output ready);
endinterface

/* design/rbb_line_store.sv */
`timescale 1ns / 1ps
// rbb_line_store: one-write one-read memory holding the even-row pair per column
// depends on rbb_pkg

module rbb_line_store
   import rbb_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [COL_W-1:0]  wr_addr,
   input  logic [PAIR_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [COL_W-1:0]  rd_addr,
   output logic [PAIR_W-1:0] rd_data
);

   logic [PAIR_W-1:0] mem [MAX_GROUPS];
   logic [PAIR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/rbb_row_ctrl.sv */
`timescale 1ns / 1ps
// rbb_row_ctrl: row length register, column counter and row phase
// depends on rbb_pkg

module rbb_row_ctrl
   import rbb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_en,
   input  logic [GPR_W-1:0] csr_write_data,
   input  logic             advance,
   output rbb_pos_type      pos
);

   logic [GPR_W-1:0] gpr_ff, gpr_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             odd_ff, odd_in;
   logic             last;

   assign last = (col_ff >= last_col(gpr_ff));

   always_comb begin
      gpr_in = csr_write_en ? csr_write_data : gpr_ff;
      col_in = col_ff;
      odd_in = odd_ff;
      if (advance) begin
         if (last) begin
            col_in = '0;
            odd_in = ~odd_ff;
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gpr_ff <= GPR_RESET;
         col_ff <= '0;
         odd_ff <= 1'b0;
      end else begin
         gpr_ff <= gpr_in;
         col_ff <= col_in;
         odd_ff <= odd_in;
      end
   end

   assign pos.col  = col_ff;
   assign pos.last = last;
   assign pos.odd  = odd_ff;

endmodule

/* design/raw12_bayer_bin_to_rgb_top.sv */
`timescale 1ns / 1ps
// raw12_bayer_bin_to_rgb_top: packed raw12 stream to 2x2 binned rgb pixels
// depends on rbb_pkg, rbb_if, rbb_line_store and rbb_row_ctrl
//
//   channel   direction  payload                                    handshake
//   req_ch    in         packed_group[23:0]                         valid/ready
//   rsp_ch    out        red, green_first, green_second, blue,      valid/ready
//                        green_mean, row_end
//   csr_*     in         csr_write_data[11:0] (groups_per_row)      csr_write_en
//
// one transaction per clock sustained while odd-row results are claimed; an odd-row
// result goes through the line store read, then the result register
// even-row transactions only write the line store and are taken every cycle
// regardless of the result side
// odd-row transactions wait in a one-entry stage after the store read, so a new
// one is still taken while a finished result sits unclaimed
// reset (synchronous) clears the counters, phase, valid flags and row length
// to 2048; the line store itself is not cleared

module raw12_bayer_bin_to_rgb_top
   import rbb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_en,
   input  logic [GPR_W-1:0] csr_write_data,
   rbb_req_if.sink          req_ch,
   rbb_rsp_if.source        rsp_ch
);

   rbb_pos_type pos;

   // selection from the incoming pair: top 8 bits of each 12-bit sample
   logic [PIX_W-1:0] samp_a;
   logic [PIX_W-1:0] samp_b;
   logic             req_fire;

   // odd-row stage between store read and result register
   logic             s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0] s1_g2_ff;
   logic [PIX_W-1:0] s1_blue_ff;
   logic             s1_last_ff;
   logic             s1_advance;
   logic [PAIR_W-1:0] pair_rd;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] red_ff, g1_ff, g2_ff, blue_ff, mean_ff;
   logic             row_end_ff;
   logic [PIX_W:0]   green_sum;

   assign samp_a = req_ch.packed_group[23:16];
   assign samp_b = req_ch.packed_group[11:4];

   // odd stage frees up when its result register is empty or being drained
   assign s1_advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !pos.odd || !s1_valid_ff || s1_advance;
   assign req_fire     = req_ch.valid && req_ch.ready;

   rbb_row_ctrl u_row_ctrl (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .advance        (req_fire),
      .pos            (pos)
   );

   // even rows park (red, green) per column, odd rows fetch it back
   rbb_line_store u_line_store (
      .clock   (clock),
      .wr_en   (req_fire && !pos.odd),
      .wr_addr (pos.col),
      .wr_data ({samp_a, samp_b}),
      .rd_en   (req_fire && pos.odd),
      .rd_addr (pos.col),
      .rd_data (pair_rd)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      if (req_fire && pos.odd) begin
         s1_valid_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // odd-row samples held alongside the store read
   always_ff @(posedge clock) begin
      if (req_fire && pos.odd) begin
         s1_g2_ff   <= samp_a;
         s1_blue_ff <= samp_b;
         s1_last_ff <= pos.last;
      end
   end

   // floor mean of both greens
   assign green_sum = {1'b0, pair_rd[PIX_W-1:0]} + {1'b0, s1_g2_ff};

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         red_ff     <= pair_rd[PAIR_W-1:PIX_W];
         g1_ff      <= pair_rd[PIX_W-1:0];
         g2_ff      <= s1_g2_ff;
         blue_ff    <= s1_blue_ff;
         mean_ff    <= green_sum[PIX_W:1];
         row_end_ff <= s1_last_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.red          = red_ff;
   assign rsp_ch.green_first  = g1_ff;
   assign rsp_ch.green_second = g2_ff;
   assign rsp_ch.blue         = blue_ff;
   assign rsp_ch.green_mean   = mean_ff;
   assign rsp_ch.row_end      = row_end_ff;

   // row end flips the phase and restarts the column
   a_row_wrap: assert property (@(posedge clock) disable iff (reset)
      req_fire && pos.last |=> pos.odd != $past(pos.odd) && pos.col == '0)
      else $error("row phase did not toggle at row end");

   // mid-row transaction steps the column by one
   a_col_step: assert property (@(posedge clock) disable iff (reset)
      req_fire && !pos.last |=> pos.col == $past(pos.col) + COL_W'(1)
                                && pos.odd == $past(pos.odd))
      else $error("column counter did not step");

   // a stalled odd-row item is kept, never dropped
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_ch.ready |=> s1_valid_ff)
      else $error("odd-row stage lost an item under stall");

   // even rows never produce a result
   a_even_quiet: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready) |=> !rsp_valid_ff)
      else $error("result appeared without an odd-row item");

endmodule
